FILE: rtl/pfba_pkg.sv
`default_nettype none

package pfba_pkg;

	// Operation codes carried on the op input.
	typedef enum logic [1:0] {
		OP_SET   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_TEST  = 2'd2,
		OP_FIND  = 2'd3
	} op_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_WIPE = 2'd0,
		ST_IDLE = 2'd1,
		ST_RMW  = 2'd2,
		ST_FIND = 2'd3
	} state_t;

	localparam int unsigned WORD_BITS = 32;
	localparam int unsigned BIT_IDX_W = 5;
	localparam int unsigned PAGE_OUT_W = 15;
	localparam int unsigned CFG_W = 16;
	localparam logic [CFG_W-1:0] PAGES_RESET = 16'd32768;

	// Outcome of checking one bitmap word during a search.
	typedef struct packed {
		logic                  has_free;
		logic                  in_limit;
		logic [PAGE_OUT_W-1:0] page;
	} scan_t;

endpackage

`default_nettype wire

FILE: rtl/pfba_ram.sv
`default_nettype none

module pfba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic      [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/pfba_scan.sv
`default_nettype none

module pfba_scan
	import pfba_pkg::*;
#(
	parameter int WA = 10,
	parameter int LW = 17
) (
	input  wire logic [WORD_BITS-1:0] word,
	input  wire logic [WA-1:0]        word_idx,
	input  wire logic [LW-1:0]        limit,
	output scan_t                     result
);

	logic [BIT_IDX_W-1:0] low_zero;
	logic [LW-1:0]        page_full;

	// Lowest clear bit of the word; the highest index is tried first so the
	// lowest one wins.
	always_comb begin
		low_zero = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!word[i]) begin
				low_zero = BIT_IDX_W'(i);
			end
		end
	end

	assign page_full = LW'({word_idx, low_zero});

	always_comb begin
		result.has_free = (word != '1);
		result.in_limit = (page_full < limit);
		result.page     = page_full[PAGE_OUT_W-1:0];
	end

endmodule

`default_nettype wire

FILE: rtl/page_frame_bitmap_allocator.sv
`default_nettype none

// Page frame bitmap allocator: one bit per physical page frame, held in a
// synchronous RAM of 32-bit words. A 1 bit marks a used frame.
// Commands enter on start with op and phys_address and are taken when busy is
// low. Set, clear and test read the addressed word as the command is taken;
// in the RMW state set and clear write it back modified, test reads its bit,
// and the result is registered onto the outputs. A set, clear or test address
// past the bitmap capacity is answered with out_of_range in the cycle after it
// is taken, without touching the RAM. Find streams words out of the RAM one per
// cycle, checking each word the cycle after its read; the walk is bounded by
// the words below pages_in_use. The RAM read port sets that pace.
// Every result is shown for one cycle with done high, and a new command can be
// taken in that same cycle. The receiver cannot stall the block.
// The pages_in_use register is written on its own channel (cfg_valid and
// cfg_ready, always ready) and must only change while no command is pending.
// After reset the block wipes all BITMAP_WORDS words of the RAM, one word per
// cycle, while busy stays high; configuration words are still taken then.
// Reset returns pages_in_use to 32768.
module page_frame_bitmap_allocator
	import pfba_pkg::*;
#(
	parameter int BITMAP_WORDS = 1024,
	parameter int PAGE_SHIFT = 12
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        op,
	input  wire logic [31:0]       phys_address,
	output logic                   done,
	output logic                   frame_used,
	output logic                   found,
	output logic [PAGE_OUT_W-1:0]  free_page,
	output logic                   out_of_range,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [CFG_W-1:0]  cfg_data
);

	localparam int WA = $clog2(BITMAP_WORDS > 1 ? BITMAP_WORDS : 2);
	localparam int LW = (WA + 6 > 17) ? WA + 6 : 17;
	localparam logic [31:0] CAP_PAGES = 32'(BITMAP_WORDS * WORD_BITS);
	localparam logic [LW-1:0] CAP_L = LW'(BITMAP_WORDS * WORD_BITS);
	localparam logic [WA-1:0] LAST_WORD = WA'(BITMAP_WORDS - 1);

	state_t state_q, state_d;

	logic [CFG_W-1:0]     pages_q;
	logic [WA-1:0]        wipe_cnt_q;
	op_t                  op_q;
	logic [WA-1:0]        idx_q;
	logic [BIT_IDX_W-1:0] bit_q;
	logic [LW-1:0]        limit_q;
	logic [WA:0]          rd_w_q;
	logic                 chk_v_q;
	logic [WA-1:0]        chk_w_q;

	// Command decode.
	logic [31:0]          page_in;
	logic                 in_oor;
	logic [WA-1:0]        idx_in;
	logic [BIT_IDX_W-1:0] bit_in;
	logic [LW-1:0]        limit_in;
	logic                 accept;

	assign page_in  = phys_address >> PAGE_SHIFT;
	assign in_oor   = (page_in >= CAP_PAGES);
	assign idx_in   = page_in[WA+BIT_IDX_W-1:BIT_IDX_W];
	assign bit_in   = page_in[BIT_IDX_W-1:0];
	assign limit_in = (LW'(pages_q) > CAP_L) ? CAP_L : LW'(pages_q);
	assign accept   = start && (state_q == ST_IDLE);

	// RAM ports.
	logic                 ram_we;
	logic [WA-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [WA-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	pfba_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(BITMAP_WORDS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Search checker for the word that just came back from the RAM.
	scan_t scan;

	pfba_scan #(
		.WA(WA),
		.LW(LW)
	) u_scan (
		.word    (ram_rdata),
		.word_idx(chk_w_q),
		.limit   (limit_q),
		.result  (scan)
	);

	// A further word may be read while its first page lies below the limit.
	logic find_issue;
	logic find_hit;
	logic find_miss;

	assign find_issue = (LW'({rd_w_q, {BIT_IDX_W{1'b0}}}) < limit_q);
	assign find_hit   = chk_v_q && scan.has_free;
	assign find_miss  = !find_issue && (!chk_v_q || !scan.has_free);

	logic [WORD_BITS-1:0] bit_mask;
	assign bit_mask = WORD_BITS'(1) << bit_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_WIPE: begin
				if (wipe_cnt_q == LAST_WORD) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept && !in_oor && op_t'(op) != OP_FIND) begin
					state_d = ST_RMW;
				end else if (accept && op_t'(op) == OP_FIND) begin
					state_d = ST_FIND;
				end
			end
			ST_RMW: begin
				state_d = ST_IDLE;
			end
			ST_FIND: begin
				if (find_hit || find_miss) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs: RAM control and the next result word.
	logic                  res_v;
	logic                  res_used;
	logic                  res_found;
	logic [PAGE_OUT_W-1:0] res_page;
	logic                  res_oor;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ram_rdata;
		ram_raddr = idx_in;
		res_v     = 1'b0;
		res_used  = 1'b0;
		res_found = 1'b0;
		res_page  = '0;
		res_oor   = 1'b0;
		case (state_q)
			ST_WIPE: begin
				ram_we    = 1'b1;
				ram_waddr = wipe_cnt_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				if (accept && in_oor && op_t'(op) != OP_FIND) begin
					res_v   = 1'b1;
					res_oor = 1'b1;
				end
			end
			ST_RMW: begin
				case (op_q)
					OP_SET: begin
						ram_we    = 1'b1;
						ram_wdata = ram_rdata | bit_mask;
					end
					OP_CLEAR: begin
						ram_we    = 1'b1;
						ram_wdata = ram_rdata & ~bit_mask;
					end
					default: begin
						res_used = |(ram_rdata & bit_mask);
					end
				endcase
				res_v = 1'b1;
			end
			ST_FIND: begin
				ram_raddr = rd_w_q[WA-1:0];
				if (find_hit) begin
					res_v     = 1'b1;
					res_found = scan.in_limit;
					res_page  = scan.in_limit ? scan.page : '0;
				end else if (find_miss) begin
					res_v = 1'b1;
				end
			end
			default: begin
				res_v = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_WIPE;
			wipe_cnt_q <= '0;
			pages_q    <= PAGES_RESET;
			chk_v_q    <= 1'b0;
			done       <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= res_v;
			if (state_q == ST_WIPE) begin
				wipe_cnt_q <= wipe_cnt_q + WA'(1);
			end
			if (cfg_valid && cfg_ready) begin
				pages_q <= cfg_data;
			end
			if (state_q == ST_FIND && !(find_hit || find_miss)) begin
				chk_v_q <= find_issue;
			end else begin
				chk_v_q <= 1'b0;
			end
		end
	end

	// Command and result payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op_t'(op);
			idx_q   <= idx_in;
			bit_q   <= bit_in;
			limit_q <= limit_in;
			rd_w_q  <= '0;
		end else if (state_q == ST_FIND && find_issue) begin
			rd_w_q  <= rd_w_q + (WA + 1)'(1);
			chk_w_q <= rd_w_q[WA-1:0];
		end
		if (res_v) begin
			frame_used   <= res_used;
			found        <= res_found;
			free_page    <= res_page;
			out_of_range <= res_oor;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

FILE: tb/frame_bitmap_checker.sv
`default_nettype none

module frame_bitmap_checker
	import pfba_pkg::*;
#(
	parameter int BITMAP_WORDS = 1024,
	parameter int PAGE_SHIFT = 12
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic                  busy,
	input  wire op_t                   op,
	input  wire logic [31:0]           phys_address,
	input  wire logic                  done,
	input  wire logic                  frame_used,
	input  wire logic                  found,
	input  wire logic [PAGE_OUT_W-1:0] free_page,
	input  wire logic                  out_of_range,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [CFG_W-1:0]      cfg_data,
	output int                         mismatches,
	output int                         outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned FRAME_CAPACITY = BITMAP_WORDS * WORD_BITS;

	typedef struct packed {
		logic                  frame_used;
		logic                  found;
		logic [PAGE_OUT_W-1:0] free_page;
		logic                  out_of_range;
	} reply_t;

	logic [WORD_BITS-1:0] frame_map [0:BITMAP_WORDS-1];
	logic [CFG_W-1:0]     search_limit;
	reply_t               expected_replies [$];
	reply_t               want;
	reply_t               got;

	initial mismatches = 0;
	initial outstanding = 0;

	// Applies one command word to the mirrored bitmap and returns its reply.
	function automatic reply_t apply_command(op_t kind, logic [31:0] addr);
		reply_t      r;
		int unsigned lim;
		int unsigned page;
		int unsigned w;
		int unsigned b;
		int unsigned p;
		logic        hit;
		logic        stop;
		r = '0;
		hit = 1'b0;
		stop = 1'b0;
		if (kind == OP_FIND) begin
			lim = search_limit;
			if (lim > FRAME_CAPACITY)
				lim = FRAME_CAPACITY;
			for (w = 0; w < BITMAP_WORDS; w++) begin
				if (!hit && !stop && w * WORD_BITS < lim && frame_map[w] != '1) begin
					for (b = 0; b < WORD_BITS; b++) begin
						p = w * WORD_BITS + b;
						if (!hit && !stop) begin
							if (p >= lim)
								stop = 1'b1;
							else if (!frame_map[w][b]) begin
								hit = 1'b1;
								r.found = 1'b1;
								r.free_page = p[PAGE_OUT_W-1:0];
							end
						end
					end
				end
			end
		end else begin
			page = addr >> PAGE_SHIFT;
			if (page >= FRAME_CAPACITY) begin
				r.out_of_range = 1'b1;
			end else begin
				case (kind)
					OP_SET:   frame_map[page / WORD_BITS][page % WORD_BITS] = 1'b1;
					OP_CLEAR: frame_map[page / WORD_BITS][page % WORD_BITS] = 1'b0;
					default:  r.frame_used = frame_map[page / WORD_BITS][page % WORD_BITS];
				endcase
			end
		end
		return r;
	endfunction

	task automatic compare_field(string name, int unsigned exp_val, int unsigned act_val);
		if (exp_val != act_val) begin
			mismatches++;
			$display("%0t: %s mismatch: expected %0d, actual %0d",
				$time, name, exp_val, act_val);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (frame_map[i])
				frame_map[i] = '0;
			search_limit = PAGES_RESET;
			expected_replies.delete();
			outstanding <= 0;
		end else begin
			if (done) begin
				got = '{frame_used, found, free_page, out_of_range};
				if (expected_replies.size() == 0) begin
					mismatches++;
					$display("%0t: reply word with none expected: actual %h", $time, got);
				end else begin
					want = expected_replies.pop_front();
					compare_field("frame_used", want.frame_used, got.frame_used);
					compare_field("found", want.found, got.found);
					compare_field("free_page", want.free_page, got.free_page);
					compare_field("out_of_range", want.out_of_range, got.out_of_range);
				end
			end
			if (cfg_valid && cfg_ready)
				search_limit = cfg_data;
			if (start && !busy)
				expected_replies.push_back(apply_command(op, phys_address));
			outstanding <= expected_replies.size();
		end
	end

endmodule

`default_nettype wire

FILE: tb/page_frame_bitmap_allocator_tb.sv
`default_nettype none

module page_frame_bitmap_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pfba_pkg::*;

	localparam int BITMAP_WORDS = 1024;
	localparam int PAGE_SHIFT = 12;
	localparam int unsigned FRAME_CAPACITY = BITMAP_WORDS * WORD_BITS;
	// Ample for every command being a full-length search with the longest gaps.
	localparam int unsigned CYCLE_LIMIT = 6_000_000;
	localparam int NUM_PHASES = 13;
	localparam int WORDS_PER_PHASE = 124;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	op_t                   op = OP_SET;
	logic [31:0]           phys_address = '0;
	logic                  done;
	logic                  frame_used;
	logic                  found;
	logic [PAGE_OUT_W-1:0] free_page;
	logic                  out_of_range;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_W-1:0]      cfg_data = '0;

	int                    mismatches;
	int                    outstanding;
	int unsigned           cycle_count = 0;
	int                    burst_left = 0;

	page_frame_bitmap_allocator #(
		.BITMAP_WORDS(BITMAP_WORDS),
		.PAGE_SHIFT  (PAGE_SHIFT)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.phys_address(phys_address),
		.done        (done),
		.frame_used  (frame_used),
		.found       (found),
		.free_page   (free_page),
		.out_of_range(out_of_range),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	frame_bitmap_checker #(
		.BITMAP_WORDS(BITMAP_WORDS),
		.PAGE_SHIFT  (PAGE_SHIFT)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.phys_address(phys_address),
		.done        (done),
		.frame_used  (frame_used),
		.found       (found),
		.free_page   (free_page),
		.out_of_range(out_of_range),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	// Watchdog: a hung handshake or a lost reply word ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Builds a byte address inside the given frame with a random offset, so the
	// low address bits toggle without changing which frame is hit.
	function automatic logic [31:0] frame_address(int unsigned page);
		logic [31:0] offset;
		offset = $urandom & ((32'd1 << PAGE_SHIFT) - 1);
		return (page << PAGE_SHIFT) | offset;
	endfunction

	// Hands one command word to the block. The sender works in bursts: within a
	// burst start stays high from word to word, and between bursts it drops for
	// a random number of cycles. A gap of zero lets two bursts run together, so
	// long stretches of back-to-back words also occur.
	task automatic issue(op_t kind, logic [31:0] addr);
		int gap;
		if (burst_left == 0)
			burst_left = $urandom_range(1, 24);
		start <= 1'b1;
		op <= kind;
		phys_address <= addr;
		// busy is read before the edge updates it, so leaving this loop means the
		// word was taken at the edge just passed.
		do @(posedge clk); while (busy);
		burst_left--;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stops the sender and waits until every reply word has come back. The
	// checker updates its count after each edge, so one edge is always let pass
	// first to see the count of the last word taken.
	task automatic drain();
		start <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Changes the search limit. Every command yields exactly one reply, so once
	// none is outstanding the block is idle and the register may change.
	task automatic write_page_limit(logic [CFG_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Search limits visited by the random phases: tiny regions that fill up
	// quickly, limits on and around a 32-bit row edge, and the extremes.
	function automatic logic [CFG_W-1:0] phase_limit(int k);
		case (k)
			0:       return 16'd32;
			1:       return 16'd33;
			2:       return 16'd64;
			3:       return 16'd0;
			4:       return 16'd1;
			5:       return 16'd100;
			6:       return 16'd31;
			7:       return 16'd2000;
			8:       return 16'd32768;
			9:       return 16'hFFFF;
			10:      return 16'd160;
			11:      return 16'd32767;
			default: return 16'd96;
		endcase
	endfunction

	// Set-heavy phases drive the searched region toward full, so the search has
	// to skip full rows and sometimes finds nothing; the others free frames
	// again.
	function automatic op_t pick_op(bit set_heavy);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (set_heavy) begin
			if (roll < 45) return OP_SET;
			if (roll < 55) return OP_CLEAR;
			if (roll < 75) return OP_TEST;
			return OP_FIND;
		end
		if (roll < 30) return OP_SET;
		if (roll < 55) return OP_CLEAR;
		if (roll < 75) return OP_TEST;
		return OP_FIND;
	endfunction

	// Most addresses land in a window just around the searched region; a few
	// are fully random (almost always past capacity) or straddle the capacity
	// edge.
	function automatic logic [31:0] pick_address(int unsigned window);
		int unsigned mode;
		mode = $urandom_range(0, 19);
		if (mode < 2)
			return $urandom;
		if (mode == 2)
			return frame_address(FRAME_CAPACITY - 8 + $urandom_range(0, 15));
		return frame_address($urandom_range(0, window - 1));
	endfunction

	initial begin
		int          k;
		int          n;
		int unsigned limit_eff;
		int unsigned window;
		logic [CFG_W-1:0] lim;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words. After reset the whole bitmap is free and searched.
		issue(OP_FIND, 32'h0000_0000);
		issue(OP_SET, 32'h0000_0000);
		issue(OP_TEST, 32'h0000_0000);
		issue(OP_TEST, 32'h0000_0FFF);
		issue(OP_FIND, 32'h1234_5678);
		// Last frame inside capacity, then the first one past it.
		issue(OP_SET, 32'h07FF_F000);
		issue(OP_TEST, 32'h07FF_FFFF);
		issue(OP_SET, 32'h0800_0000);
		issue(OP_CLEAR, 32'hFFFF_FFFF);
		issue(OP_TEST, 32'hFFFF_F000);
		issue(OP_FIND, 32'hFFFF_FFFF);
		issue(OP_CLEAR, 32'h0000_0000);
		issue(OP_TEST, 32'h0000_0000);
		issue(OP_FIND, 32'h0000_0000);
		// A single searched frame that is used: nothing free.
		write_page_limit(16'd1);
		issue(OP_SET, 32'h0000_0ABC);
		issue(OP_FIND, 32'h0000_0000);
		// An empty search region never finds anything.
		write_page_limit(16'd0);
		issue(OP_FIND, 32'h0000_0000);
		// A limit above capacity is cut down to capacity.
		write_page_limit(16'hFFFF);
		issue(OP_FIND, 32'h0000_0000);
		issue(OP_SET, 32'h0000_1000);
		issue(OP_FIND, 32'h0000_0000);
		issue(OP_TEST, 32'h0000_1FFF);

		// Random phases, each with its own search limit and operation mix. The
		// bitmap carries over from phase to phase.
		for (k = 0; k < NUM_PHASES; k++) begin
			lim = phase_limit(k);
			write_page_limit(lim);
			limit_eff = (lim > FRAME_CAPACITY) ? FRAME_CAPACITY : lim;
			window = (limit_eff <= 200) ? limit_eff + 8 : 192;
			for (n = 0; n < WORDS_PER_PHASE; n++)
				issue(pick_op(k % 2 == 0), pick_address(window));
		end

		// Wait for the last reply, then long enough for a full search so that a
		// stray reply word would still be caught.
		drain();
		repeat (BITMAP_WORDS + 8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
